### hw/rtl/ipfb_pkg.sv
package ipfb_pkg;

  // input item opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // result kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_ARP   = 1'b1;

  // configuration register indexes
  localparam logic CFG_OWN_IP  = 1'b0;
  localparam logic CFG_OWN_MAC = 1'b1;

  // queue entry classes
  localparam logic [1:0] CLS_HDR  = 2'd0;
  localparam logic [1:0] CLS_ARP  = 2'd1;
  localparam logic [1:0] CLS_DATA = 2'd2;

  localparam int          HDR_BYTES  = 34;
  localparam int          IDX_W      = 6;
  localparam logic [15:0] ETHERTYPE  = 16'h0800;
  localparam logic [7:0]  VER_IHL    = 8'h45;
  localparam logic [7:0]  IP_TOS     = 8'h00;
  localparam logic [15:0] IP_ID      = 16'h0001;
  localparam logic [15:0] IP_FRAG    = 16'h0000;
  localparam logic [7:0]  IP_TTL     = 8'd64;
  localparam logic [15:0] IP_HDR_LEN = 16'd20;

  typedef struct packed {
    logic        op;
    logic [31:0] dest_ip;
    logic [47:0] dest_mac;
    logic        dest_mac_known;
    logic [7:0]  proto_number;
    logic [10:0] payload_length;
    logic [7:0]  payload_byte;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] frame_byte;
    logic       frame_last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0]  cls;
    logic [31:0] dest_ip;
    logic [47:0] dest_mac;
    logic [7:0]  proto;
    logic [10:0] plen;
    logic [7:0]  pbyte;
    logic        last;
  } entry_t;

endpackage

### hw/rtl/ipfb_front.sv
module ipfb_front import ipfb_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 1500
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  in_beat_t in_data,
  input  logic     q_full,
  output logic     in_stall,
  output logic     push,
  output entry_t   push_data
);

  localparam logic [31:0] MAXP = 32'(MAX_FRAME_BYTES - HDR_BYTES);

  logic        packet_open;
  logic [10:0] bytes_left;
  logic        packet_open_next;
  logic [10:0] bytes_left_next;
  logic        accept;
  logic [10:0] plen_sat;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    plen_sat = ({21'd0, in_data.payload_length} > MAXP) ? MAXP[10:0]
                                                        : in_data.payload_length;
  end

  always_comb begin
    packet_open_next    = packet_open;
    bytes_left_next     = bytes_left;
    push                = 1'b0;
    push_data.cls       = CLS_DATA;
    push_data.dest_ip   = in_data.dest_ip;
    push_data.dest_mac  = in_data.dest_mac;
    push_data.proto     = in_data.proto_number;
    push_data.plen      = plen_sat;
    push_data.pbyte     = in_data.payload_byte;
    push_data.last      = (bytes_left == 11'd1);
    if (accept) begin
      if (in_data.op == OP_START) begin
        push = 1'b1;
        if (in_data.dest_mac_known) begin
          push_data.cls    = CLS_HDR;
          packet_open_next = (plen_sat != 11'd0);
          bytes_left_next  = plen_sat;
        end else begin
          push_data.cls    = CLS_ARP;
          packet_open_next = 1'b0;
          bytes_left_next  = 11'd0;
        end
      end else if (packet_open && bytes_left != 11'd0) begin
        push            = 1'b1;
        bytes_left_next = bytes_left - 11'd1;
        if (bytes_left == 11'd1) begin
          packet_open_next = 1'b0;
        end
      end else begin
        // stray byte: dropped
        packet_open_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      bytes_left  <= 11'd0;
    end else begin
      packet_open <= packet_open_next;
      bytes_left  <= bytes_left_next;
    end
  end

endmodule

### hw/rtl/ipfb_queue.sv
module ipfb_queue import ipfb_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   head_valid,
  output entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

### hw/rtl/ipfb_back.sv
module ipfb_back import ipfb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head,
  input  logic [31:0] own_ip,
  input  logic [47:0] own_mac,
  input  logic        out_stall,
  output logic        pop,
  output logic        out_valid,
  output out_beat_t   out_data
);

  logic [IDX_W-1:0] idx;
  logic [19:0]      acc;
  logic             load;
  logic             fire;
  logic             hdr_end;
  logic [15:0]      tot;
  logic [15:0]      ck;
  logic [7:0]       hbyte;
  out_beat_t        beat;

  assign load    = !out_valid || !out_stall;
  assign fire    = head_valid && load;
  assign hdr_end = (idx == IDX_W'(HDR_BYTES - 1));
  assign pop     = fire && (head.cls != CLS_HDR || hdr_end);
  assign tot     = IP_HDR_LEN + {5'd0, head.plen};
  assign ck      = ~acc[15:0];

  always_comb begin
    case (idx)
      6'd0:  hbyte = head.dest_mac[47:40];
      6'd1:  hbyte = head.dest_mac[39:32];
      6'd2:  hbyte = head.dest_mac[31:24];
      6'd3:  hbyte = head.dest_mac[23:16];
      6'd4:  hbyte = head.dest_mac[15:8];
      6'd5:  hbyte = head.dest_mac[7:0];
      6'd6:  hbyte = own_mac[47:40];
      6'd7:  hbyte = own_mac[39:32];
      6'd8:  hbyte = own_mac[31:24];
      6'd9:  hbyte = own_mac[23:16];
      6'd10: hbyte = own_mac[15:8];
      6'd11: hbyte = own_mac[7:0];
      6'd12: hbyte = ETHERTYPE[15:8];
      6'd13: hbyte = ETHERTYPE[7:0];
      6'd14: hbyte = VER_IHL;
      6'd15: hbyte = IP_TOS;
      6'd16: hbyte = tot[15:8];
      6'd17: hbyte = tot[7:0];
      6'd18: hbyte = IP_ID[15:8];
      6'd19: hbyte = IP_ID[7:0];
      6'd20: hbyte = IP_FRAG[15:8];
      6'd21: hbyte = IP_FRAG[7:0];
      6'd22: hbyte = IP_TTL;
      6'd23: hbyte = head.proto;
      6'd24: hbyte = ck[15:8];
      6'd25: hbyte = ck[7:0];
      6'd26: hbyte = own_ip[31:24];
      6'd27: hbyte = own_ip[23:16];
      6'd28: hbyte = own_ip[15:8];
      6'd29: hbyte = own_ip[7:0];
      6'd30: hbyte = head.dest_ip[31:24];
      6'd31: hbyte = head.dest_ip[23:16];
      6'd32: hbyte = head.dest_ip[15:8];
      6'd33: hbyte = head.dest_ip[7:0];
      default: hbyte = 8'h00;
    endcase
  end

  always_comb begin
    beat.kind       = KIND_FRAME;
    beat.frame_byte = head.pbyte;
    beat.frame_last = head.last;
    case (head.cls)
      CLS_HDR: begin
        beat.frame_byte = hbyte;
        beat.frame_last = hdr_end && (head.plen == 11'd0);
      end
      CLS_ARP: begin
        beat.kind       = KIND_ARP;
        beat.frame_byte = 8'h00;
        beat.frame_last = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // checksum built over the first five header beats, long before byte 24
  always_ff @(posedge clk) begin
    if (fire && head.cls == CLS_HDR) begin
      case (idx)
        6'd0: acc <= 20'({VER_IHL, IP_TOS}) + 20'(IP_ID) + 20'({IP_TTL, 8'h00})
                     + 20'(IP_FRAG) + 20'(head.proto) + 20'(tot);
        6'd1: acc <= acc + 20'(own_ip[31:16]) + 20'(own_ip[15:0]);
        6'd2: acc <= acc + 20'(head.dest_ip[31:16]) + 20'(head.dest_ip[15:0]);
        6'd3: acc <= 20'(acc[15:0]) + 20'(acc[19:16]);
        6'd4: acc <= 20'(acc[15:0]) + 20'(acc[19:16]);
        default: acc <= acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= beat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= head_valid;
      end
      if (fire && head.cls == CLS_HDR) begin
        idx <= hdr_end ? '0 : idx + 1'b1;
      end
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_W'(HDR_BYTES - 1))
    else $error("header index out of range");
  a_idx_only_hdr: assert property (@(posedge clk) disable iff (rst)
    (idx != '0) |-> (head_valid && head.cls == CLS_HDR))
    else $error("header in progress without header entry at head");
  a_pop_fire: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("entry retired without a beat");

endmodule

### hw/rtl/ipv4_ethernet_frame_builder.sv
// IPv4-over-Ethernet frame builder. A start beat (op 0) with a known destination MAC
// produces a 34-beat header: destination MAC, own MAC, ethertype 0x0800, then a 20-byte
// IPv4 header (0x45, TOS 0, total length 20 + payload, id 1, no fragmentation, TTL 64,
// protocol, ones'-complement checksum, own IP, destination IP), all most significant byte
// first. An unknown MAC gives one ARP beat (kind 1) instead and opens no packet. Payload
// beats (op 1) pass one byte per cycle unless stalled, the last marked by frame_last;
// stray payload beats are dropped, a payload length too large for MAX_FRAME_BYTES is
// clipped, and a new start abandons an open packet. The front classifies one input beat
// per cycle unless the queue is full and keeps the open packet's byte count; a queue of
// QUEUE_DEPTH entries feeds the back end, which emits one output beat per cycle unless
// out_stall holds it, via a registered output stage; input stalls only when the queue is
// full. own_ip and own_mac are written via cfg_write/cfg_index/cfg_data; the user must
// do so only while the block is idle; unenforced. No clearing pass is needed after reset.
module ipv4_ethernet_frame_builder import ipfb_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 1500,
  parameter int QUEUE_DEPTH     = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [47:0] cfg_data
);

  logic [31:0] own_ip;
  logic [47:0] own_mac;

  // queue hook-up
  logic   q_full;
  logic   push;
  entry_t push_data;
  logic   pop;
  logic   head_valid;
  entry_t head;

  // config registers; the user must write them only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= 32'd0;
      own_mac <= 48'd0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_OWN_IP:  own_ip  <= cfg_data[31:0];
        CFG_OWN_MAC: own_mac <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // front: takes input beats, tracks the open packet, classifies each beat
  ipfb_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .in_stall  (in_stall),
    .push      (push),
    .push_data (push_data)
  );

  // decoupling queue: the header burst drains while input keeps arriving
  ipfb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // back: expands entries into output beats, header checksum built on the way
  ipfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .own_ip     (own_ip),
    .own_mac    (own_mac),
    .out_stall  (out_stall),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

### bench/tb_ipv4_ethernet_frame_builder.sv
module tb_ipv4_ethernet_frame_builder;
  import ipfb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // DUT sizing, kept equal to the block's default
  localparam int          MAX_FRAME   = 1500;
  localparam logic [10:0] MAX_PLEN    = 11'(MAX_FRAME - HDR_BYTES);
  // quiet time after the last owed beat: a full queue of headers plus the output stage
  localparam int          SETTLE      = 200;
  // timeout, well above the slowest legal run
  localparam int          CYCLE_LIMIT = 1_200_000;
  // useful beats per random phase (beats that make at least one result)
  localparam int          PHASE_BEATS = 85;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic        cfg_write;
  logic        cfg_index;
  logic [47:0] cfg_data;

  ipv4_ethernet_frame_builder #(
    .MAX_FRAME_BYTES(MAX_FRAME)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Frame predictor: own copy of the address registers and the packet state.
  // Each accepted input beat is run through frame_step, which leaves the
  // output beats it causes in step_beats; those are queued in owed_beats and
  // consumed, oldest first, by the output checker.
  // ---------------------------------------------------------------------------
  logic [31:0] model_ip;
  logic [47:0] model_mac;
  logic        pkt_open;
  logic [10:0] bytes_left;

  out_beat_t step_beats[$];
  out_beat_t owed_beats[$];

  int faults;
  int useful_items;   // input beats that caused at least one output beat
  int cycle_count;
  int tx_calm;        // beats left in a no-gap stretch, sender side
  int rx_calm;        // same, receiver side
  bit hold_off;       // long receiver hold-off, driven by its own process

  typedef struct {
    in_beat_t  beat;
    int        typed_n;   // -1: use predictor, else number of typed results
    out_beat_t typed;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic out_beat_t beat_of(logic k, logic [7:0] d, logic l);
    out_beat_t o;
    o.kind       = k;
    o.frame_byte = d;
    o.frame_last = l;
    return o;
  endfunction

  function automatic void frame_step(input in_beat_t b);
    logic [7:0]  hdr [HDR_BYTES];
    logic [10:0] len;
    logic [15:0] tot;
    logic [31:0] acc;
    logic [15:0] csum;
    step_beats.delete();
    if (b.op == OP_START) begin
      // a start always abandons whatever packet was open
      pkt_open   = 1'b0;
      bytes_left = '0;
      if (!b.dest_mac_known) begin
        step_beats.push_back(beat_of(KIND_ARP, 8'h00, 1'b0));
      end else begin
        len = (b.payload_length > MAX_PLEN) ? MAX_PLEN : b.payload_length;
        tot = IP_HDR_LEN + 16'(len);
        for (int i = 0; i < 6; i++) begin
          hdr[i]     = b.dest_mac[47 - 8*i -: 8];
          hdr[6 + i] = model_mac[47 - 8*i -: 8];
        end
        hdr[12] = ETHERTYPE[15:8];
        hdr[13] = ETHERTYPE[7:0];
        hdr[14] = VER_IHL;
        hdr[15] = IP_TOS;
        hdr[16] = tot[15:8];
        hdr[17] = tot[7:0];
        hdr[18] = IP_ID[15:8];
        hdr[19] = IP_ID[7:0];
        hdr[20] = IP_FRAG[15:8];
        hdr[21] = IP_FRAG[7:0];
        hdr[22] = IP_TTL;
        hdr[23] = b.proto_number;
        hdr[24] = 8'h00;
        hdr[25] = 8'h00;
        for (int i = 0; i < 4; i++) begin
          hdr[26 + i] = model_ip[31 - 8*i -: 8];
          hdr[30 + i] = b.dest_ip[31 - 8*i -: 8];
        end
        // ones'-complement sum over the 20 IPv4 bytes, checksum field zero
        acc = '0;
        for (int k = 14; k < HDR_BYTES; k += 2)
          acc += {16'h0000, hdr[k], hdr[k + 1]};
        acc  = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
        acc  = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
        csum = ~acc[15:0];
        hdr[24] = csum[15:8];
        hdr[25] = csum[7:0];
        for (int i = 0; i < HDR_BYTES; i++)
          step_beats.push_back(beat_of(KIND_FRAME, hdr[i],
                                       (len == 0) && (i == HDR_BYTES - 1)));
        if (len != 0) begin
          pkt_open   = 1'b1;
          bytes_left = len;
        end
      end
    end else if (pkt_open && bytes_left != 0) begin
      bytes_left = bytes_left - 11'd1;
      step_beats.push_back(beat_of(KIND_FRAME, b.payload_byte, bytes_left == 0));
      if (bytes_left == 0)
        pkt_open = 1'b0;
    end else begin
      // stray payload byte: dropped
      pkt_open = 1'b0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic in_beat_t start_beat(logic [31:0] ip, logic [47:0] mac, logic known,
                                          logic [7:0] proto, logic [10:0] plen);
    in_beat_t b;
    b                = '0;
    b.op             = OP_START;
    b.dest_ip        = ip;
    b.dest_mac       = mac;
    b.dest_mac_known = known;
    b.proto_number   = proto;
    b.payload_length = plen;
    return b;
  endfunction

  // unused header fields left all ones on directed payload beats
  function automatic in_beat_t data_beat(logic [7:0] d);
    in_beat_t b;
    b              = '1;
    b.op           = OP_DATA;
    b.payload_byte = d;
    return b;
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    b.op             = 1'($urandom);
    b.dest_ip        = $urandom;
    b.dest_mac       = {16'($urandom), $urandom};
    b.dest_mac_known = 1'($urandom);
    b.proto_number   = 8'($urandom);
    b.payload_length = 11'($urandom);
    b.payload_byte   = 8'($urandom);
    return b;
  endfunction

  function automatic void add_row(in_beat_t b, int n, out_beat_t o);
    dir_row_t r;
    r.beat    = b;
    r.typed_n = n;
    r.typed   = o;
    dir_rows.push_back(r);
  endfunction

  // Offer one beat, wait for it to be taken, then book what it owes.
  // Called just after a rising edge (or at time zero after reset).
  task automatic send_item(input in_beat_t b, input int typed_n, input out_beat_t typed);
    int gap;
    @(negedge clk);
    if (tx_calm > 0) begin
      tx_calm--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 19) == 0)
        tx_calm = $urandom_range(10, 40);
      gap = $urandom_range(0, 14);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // predictor runs on every beat so its state tracks the block
    frame_step(b);
    if (step_beats.size() > 0)
      useful_items++;
    if (typed_n < 0) begin
      foreach (step_beats[i]) owed_beats.push_back(step_beats[i]);
    end else begin
      repeat (typed_n) owed_beats.push_back(typed);
    end
  endtask

  // One random packet: mostly a start with its payload, sometimes cut short,
  // sometimes overrun, sometimes stray noise on its own.
  task automatic send_burst();
    in_beat_t b;
    int       r;
    int       n;
    b = rand_beat();
    r = $urandom_range(0, 99);
    if (r < 8) begin
      b.op = OP_DATA;
      send_item(b, -1, '0);
    end else begin
      b.op             = OP_START;
      b.dest_mac_known = ($urandom_range(0, 9) != 0);
      r = $urandom_range(0, 99);
      if (r < 10)      b.payload_length = 11'd0;
      else if (r < 75) b.payload_length = 11'($urandom_range(1, 8));
      else if (r < 92) b.payload_length = 11'($urandom_range(9, 40));
      else             b.payload_length = 11'($urandom_range(1024, 2047));
      send_item(b, -1, '0);
      // long packets are abandoned after a handful of bytes
      n = (b.payload_length > 40) ? $urandom_range(1, 10) : int'(b.payload_length);
      r = $urandom_range(0, 9);
      if (r == 0 && n > 0) n--;
      else if (r == 1)     n++;
      repeat (n) begin
        b    = rand_beat();
        b.op = OP_DATA;
        send_item(b, -1, '0);
      end
    end
  endtask

  // Wait for every owed beat, then for anything still in flight inside.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (owed_beats.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write both address registers; top bits of the IP write carry junk.
  task automatic set_addresses(input logic [31:0] ip, input logic [47:0] mac);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= CFG_OWN_IP;
    cfg_data  <= {16'($urandom), ip};
    model_ip   = ip;
    @(negedge clk);
    cfg_index <= CFG_OWN_MAC;
    cfg_data  <= mac;
    model_mac  = mac;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall per beat, no-stall stretches, and one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int w;
    out_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (rx_calm > 0) begin
        rx_calm--;
        w = 0;
      end else begin
        if ($urandom_range(0, 19) == 0)
          rx_calm = $urandom_range(20, 80);
        w = $urandom_range(0, 14);
      end
      if (w > 0 || hold_off) begin
        out_stall <= 1'b1;
        repeat ((w > 0) ? w : 1) @(negedge clk);
        while (hold_off) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // long hold-off while the sender keeps going: the queue fills and in_stall rises
  initial begin
    hold_off = 1'b0;
    wait (useful_items >= 150);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Output checker: every accepted beat against the oldest owed one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (owed_beats.size() == 0) begin
        if (faults < 10)
          $display("unexpected beat: kind %0d byte %02h last %0d",
                   out_data.kind, out_data.frame_byte, out_data.frame_last);
        faults++;
      end else begin
        want = owed_beats.pop_front();
        if (out_data.kind != want.kind || out_data.frame_byte != want.frame_byte ||
            out_data.frame_last != want.frame_last) begin
          if (faults < 10)
            $display("beat mismatch: want kind %0d byte %02h last %0d, got %0d %02h %0d",
                     want.kind, want.frame_byte, want.frame_last,
                     out_data.kind, out_data.frame_byte, out_data.frame_last);
          faults++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int target;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_write  = 1'b0;
    cfg_index  = CFG_OWN_IP;
    cfg_data   = '0;
    model_ip   = '0;
    model_mac  = '0;
    pkt_open   = 1'b0;
    bytes_left = '0;
    faults       = 0;
    useful_items = 0;
    cycle_count  = 0;
    tx_calm      = 0;
    rx_calm      = 0;

    // Directed rows, run with the address registers still at reset (zero).
    // Typed results only where obvious: stray bytes owe nothing, a miss
    // owes one ARP beat with byte and last both zero.
    add_row(data_beat(8'h00), 0, '0);                         // stray after reset
    add_row(start_beat(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0, 8'hFF, 11'd5),
            1, beat_of(KIND_ARP, 8'h00, 1'b0));               // MAC miss
    add_row(data_beat(8'hFF), 0, '0);                         // dropped after a miss
    add_row(start_beat(32'h0, 48'h0, 1'b1, 8'h00, 11'd0), -1, '0);  // empty payload
    add_row(data_beat(8'hA5), 0, '0);                         // nothing open after it
    add_row(start_beat(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, 8'hFF, 11'd2), -1, '0);
    add_row(data_beat(8'h00), -1, '0);
    add_row(data_beat(8'hFF), -1, '0);                        // last byte marked
    add_row(data_beat(8'h3C), 0, '0);                         // overrun byte
    add_row(start_beat(32'hC0A8_0001, 48'h0123_4567_89AB, 1'b1, 8'h06, 11'h7FF),
            -1, '0);                                          // clipped length
    add_row(data_beat(8'h11), -1, '0);
    add_row(data_beat(8'h22), -1, '0);
    add_row(start_beat(32'h0A00_0001, 48'h0200_0000_0001, 1'b1, 8'h11, MAX_PLEN),
            -1, '0);                                          // largest legal, abandons
    add_row(data_beat(8'h33), -1, '0);
    add_row(start_beat(32'h8000_0000, 48'h8000_0000_0000, 1'b1, 8'h80, MAX_PLEN + 11'd1),
            -1, '0);                                          // one over the limit
    add_row(start_beat(32'h7F00_0001, 48'h5A5A_5A5A_5A5A, 1'b1, 8'h01, 11'd1),
            -1, '0);
    add_row(data_beat(8'h80), -1, '0);
    add_row(start_beat(32'h1234_5678, 48'hA5A5_A5A5_A5A5, 1'b1, 8'h06, 11'd3), -1, '0);
    add_row(data_beat(8'h44), -1, '0);
    add_row(start_beat(32'h0101_0101, 48'h0, 1'b0, 8'h00, 11'd4),
            1, beat_of(KIND_ARP, 8'h00, 1'b0));               // miss abandons open packet
    add_row(data_beat(8'h55), 0, '0);

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item(dir_rows[i].beat, dir_rows[i].typed_n, dir_rows[i].typed);
    drain();

    // random phases, each under its own address setting
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_addresses(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        end
        2: begin
          set_addresses(32'h0, 48'h0);
        end
        default: begin
          set_addresses($urandom, {16'($urandom), $urandom});
        end
      endcase
      target = useful_items + PHASE_BEATS;
      while (useful_items < target) send_burst();
      drain();
    end

    if (faults == 0 && owed_beats.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/ipfb_pkg.sv
hw/rtl/ipfb_front.sv
hw/rtl/ipfb_queue.sv
hw/rtl/ipfb_back.sv
hw/rtl/ipv4_ethernet_frame_builder.sv
bench/tb_ipv4_ethernet_frame_builder.sv
